// ===== rtl/proof_digest_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// Proof digest accumulator assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during rst_ni.
// ----------------------------------------------------------------------------
`ifndef PROOF_DIGEST_ACCUMULATOR_DEFINES_SVH
`define PROOF_DIGEST_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTH
// Checks a property on every rising clock edge outside reset.
`define PDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("proof digest accumulator: property failed");
// Checks that a condition never holds on any rising clock edge outside reset.
`define PDA_ASSERT_NEVER(lbl, cond) \
  `PDA_ASSERT(lbl, !(cond))
`else
`define PDA_ASSERT(lbl, prop)
`define PDA_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/pda_pkg.sv =====
// ----------------------------------------------------------------------------
// Proof digest accumulator package
// Shared types, register indexes and mixing constants.
// ----------------------------------------------------------------------------
package pda_pkg;

  // Item operation codes as they arrive on the opcode port.
  typedef enum logic [1:0] {
    OP_FEED   = 2'd0,
    OP_WINDOW = 2'd1,
    OP_FINISH = 2'd2
  } opcode_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOT_BEFORE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOT_AFTER = 3'd4;

  // Mixer constants.
  localparam logic [63:0] MIX_MUL1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL2   = 64'h94D049BB133111EB;
  localparam logic [63:0] FEED_SALT  = 64'h2D358DCCAA6C78A5;
  localparam logic [63:0] WIN_IN     = 64'h7C2F9A13E5D084B6;
  localparam logic [63:0] WIN_OUT    = 64'hE19B4D7608C35AF1;
  localparam logic [63:0] WIN_SALT   = 64'h4A2F81D95C76B3E0;
  localparam logic [63:0] MISS_TAG   = 64'hD6E8FEB86659FD93;
  localparam logic [63:0] MISS_SALT  = 64'hE7037ED1A0B428DB;
  localparam logic [63:0] WINDOW_BIT = 64'h0000000000000004;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One configuration write as seen by the modules that own registers.
  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
  } cfg_wr_t;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    opcode_e     kind;
    logic [63:0] domain;
    logic [7:0]  data_byte;
    logic        last;
    logic        in_window;
  } pda_item_t;

  // Request to the mixer.
  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [63:0] salt;
  } mix_req_t;

  // Status and result from the mixer.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } mix_rsp_t;

endpackage

// ===== rtl/proof_digest_accumulator.sv =====
// ----------------------------------------------------------------------------
// Proof digest accumulator
// Folds feed bytes and epoch window checks into a 64-bit digest and answers
// finish requests with a word that is zero only for the expected proof.
// ----------------------------------------------------------------------------
// The block works on one word at a time in its back end. A feed byte, a
// window check and a failing finish each run the salted splitmix64 finalizer
// once: the operand is loaded and pre-shifted, then each of the two 64-bit
// multiplies runs as a low partial product step and then a cross-term and
// sum step, built from 32-bit partial products on the mixer's multipliers.
// A passing finish needs no mixing. The front end takes a new word whenever
// its two-entry queue has room, so the input side keeps accepting while the
// back end mixes or while a finish word waits to be popped. Opcode 3 is
// accepted and dropped. Configuration writes are always ready and must only
// be issued while the block is idle; writing the seed register also reloads
// the digest. There is no clearing pass after reset.
`include "proof_digest_accumulator_defines.svh"

module proof_digest_accumulator import pda_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  // Input word side.
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           opcode_i,
  input  logic [63:0]          domain_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_i,
  input  logic [63:0]          now_epoch_i,
  // Result word side.
  output logic                 empty,
  input  logic                 pop,
  output logic [63:0]          contribution_o
);

  cfg_wr_t   cfg_wr;
  logic      q_push, q_full, q_empty, q_pop;
  pda_item_t q_wdata, q_rdata;
  mix_req_t  mix_req;
  mix_rsp_t  mix_rsp;
  logic      out_valid;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  pda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .push_i      (push),
    .full_o      (full),
    .opcode_i    (opcode_i),
    .domain_i    (domain_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .now_epoch_i (now_epoch_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_wdata)
  );

  pda_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  pda_mix u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mix_req),
    .rsp_o  (mix_rsp)
  );

  pda_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_i       (cfg_wr),
    .q_empty_i      (q_empty),
    .q_item_i       (q_rdata),
    .q_pop_o        (q_pop),
    .mix_req_o      (mix_req),
    .mix_rsp_i      (mix_rsp),
    .pop_i          (pop),
    .out_valid_o    (out_valid),
    .contribution_o (contribution_o)
  );

  assign empty = !out_valid;

  // The back end must never start the mixer while it is still working.
  `PDA_ASSERT_NEVER(a_mix_overlap, mix_req.start && mix_rsp.busy)
  // A mixer result only appears after the mixer has been busy.
  `PDA_ASSERT(a_mix_done_busy, mix_rsp.done |-> $past(mix_rsp.busy))
  // The front end never pushes into a full queue.
  `PDA_ASSERT_NEVER(a_q_overflow, q_push && q_full)
  // The back end never takes a word from an empty queue.
  `PDA_ASSERT_NEVER(a_q_underflow, q_pop && q_empty)

endmodule

// ===== rtl/pda_fifo.sv =====
// ----------------------------------------------------------------------------
// Proof digest accumulator item queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pda_fifo import pda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pda_item_t wdata_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      empty_o,
  output pda_item_t rdata_o
);

  pda_item_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/pda_front.sv =====
// ----------------------------------------------------------------------------
// Proof digest accumulator front end
// Accepts input words, runs the epoch window check and queues the work.
// ----------------------------------------------------------------------------
module pda_front import pda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_wr_t     cfg_wr_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] domain_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic [63:0] now_epoch_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output pda_item_t   q_item_o
);

  logic [63:0] not_before_q;
  logic [63:0] not_after_q;
  logic        lower_ok, upper_ok, known_op;

  // The epoch bounds are only needed here, so they live in the front.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      not_before_q <= '0;
      not_after_q  <= '0;
    end else if (cfg_wr_i.valid) begin
      case (cfg_wr_i.index)
        REG_NOT_BEFORE: not_before_q <= cfg_wr_i.data;
        REG_NOT_AFTER:  not_after_q  <= cfg_wr_i.data;
        default: ;
      endcase
    end
  end

  assign lower_ok = (not_before_q == '0) || (now_epoch_i >= not_before_q);
  assign upper_ok = (not_after_q == '0) || (now_epoch_i <= not_after_q);

  // The unused opcode is taken and dropped without reaching the queue.
  assign known_op = (opcode_i == OP_FEED) || (opcode_i == OP_WINDOW) ||
                    (opcode_i == OP_FINISH);

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i && known_op;

  always_comb begin
    q_item_o.kind      = opcode_e'(opcode_i);
    q_item_o.domain    = domain_i;
    q_item_o.data_byte = data_byte_i;
    q_item_o.last      = last_i;
    q_item_o.in_window = lower_ok && upper_ok;
  end

endmodule

// ===== rtl/pda_mix.sv =====
// ----------------------------------------------------------------------------
// Proof digest accumulator mixer
// Salted splitmix64 finalizer built from 32-bit partial products.
// ----------------------------------------------------------------------------
module pda_mix import pda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mix_req_t req_i,
  output mix_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    MX_IDLE,
    MX_M1A,
    MX_M1B,
    MX_M2A,
    MX_M2B
  } mx_state_e;

  mx_state_e   state_q;
  logic [63:0] x_q;
  logic [63:0] plo_q;
  logic [63:0] salted, mul_c, plo_d, prod;
  logic [31:0] cross_a, cross_b;

  assign salted = req_i.x ^ req_i.salt;
  assign mul_c  = ((state_q == MX_M1A) || (state_q == MX_M1B)) ? MIX_MUL1 : MIX_MUL2;

  // Low partial product in the first state of a multiply (M1A, M2A), the two
  // cross terms (only their low halves matter) and the sum in the second.
  assign plo_d   = x_q[31:0] * mul_c[31:0];
  assign cross_a = x_q[31:0] * mul_c[63:32];
  assign cross_b = x_q[63:32] * mul_c[31:0];
  assign prod    = plo_q + {cross_a + cross_b, 32'd0};

  assign rsp_o.busy   = (state_q != MX_IDLE);
  assign rsp_o.done   = (state_q == MX_M2B);
  assign rsp_o.result = prod ^ (prod >> 31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MX_IDLE;
      x_q     <= '0;
      plo_q   <= '0;
    end else begin
      case (state_q)
        MX_IDLE: begin
          if (req_i.start) begin
            x_q     <= salted ^ (salted >> 30);
            state_q <= MX_M1A;
          end
        end
        MX_M1A: begin
          plo_q   <= plo_d;
          state_q <= MX_M1B;
        end
        MX_M1B: begin
          x_q     <= prod ^ (prod >> 27);
          state_q <= MX_M2A;
        end
        MX_M2A: begin
          plo_q   <= plo_d;
          state_q <= MX_M2B;
        end
        MX_M2B: begin
          state_q <= MX_IDLE;
        end
        default: begin
          state_q <= MX_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/pda_back.sv =====
// ----------------------------------------------------------------------------
// Proof digest accumulator back end
// Holds the digest state, drives the mixer and produces finish words.
// ----------------------------------------------------------------------------
module pda_back import pda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_wr_t     cfg_wr_i,
  input  logic        q_empty_i,
  input  pda_item_t   q_item_i,
  output logic        q_pop_o,
  output mix_req_t    mix_req_o,
  input  mix_rsp_t    mix_rsp_i,
  input  logic        pop_i,
  output logic        out_valid_o,
  output logic [63:0] contribution_o
);

  typedef enum logic {
    BK_IDLE,
    BK_WAIT
  } bk_state_e;

  bk_state_e   state_q;
  opcode_e     kind_q;
  logic        last_q;
  logic [5:0]  bit_sel_q;
  logic [63:0] digest_q;
  logic [63:0] mask_q;
  logic        seen_q;
  logic [63:0] cnt_q;
  logic [63:0] expected_q;
  logic [63:0] required_q;
  logic        out_valid_q;
  logic [63:0] out_q;
  logic        pass, stall;

  assign pass = seen_q && ((mask_q & required_q) == required_q);

  // A finish has to wait until the previous finish word has been taken.
  assign stall = (q_item_i.kind == OP_FINISH) && out_valid_q;

  always_comb begin
    q_pop_o        = (state_q == BK_IDLE) && !q_empty_i && !stall;
    mix_req_o.start = 1'b0;
    mix_req_o.x     = digest_q ^ q_item_i.domain ^ cnt_q ^ {56'd0, q_item_i.data_byte};
    mix_req_o.salt  = FEED_SALT;
    case (q_item_i.kind)
      OP_FEED: begin
        mix_req_o.start = q_pop_o;
      end
      OP_WINDOW: begin
        mix_req_o.start = q_pop_o;
        mix_req_o.x     = digest_q ^ (q_item_i.in_window ? WIN_IN : WIN_OUT);
        mix_req_o.salt  = WIN_SALT;
      end
      OP_FINISH: begin
        mix_req_o.start = q_pop_o && !pass;
        mix_req_o.x     = digest_q ^ q_item_i.domain ^ mask_q ^ required_q ^ MISS_TAG;
        mix_req_o.salt  = MISS_SALT;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign contribution_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      kind_q      <= OP_FEED;
      last_q      <= 1'b0;
      bit_sel_q   <= '0;
      digest_q    <= '0;
      mask_q      <= '0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      expected_q  <= 64'd1;
      required_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BK_IDLE: begin
          if (q_pop_o) begin
            kind_q    <= q_item_i.kind;
            last_q    <= q_item_i.last;
            bit_sel_q <= q_item_i.domain[5:0];
            if ((q_item_i.kind == OP_FINISH) && pass) begin
              out_q       <= digest_q ^ expected_q;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= BK_WAIT;
            end
          end
        end
        BK_WAIT: begin
          if (mix_rsp_i.done) begin
            state_q <= BK_IDLE;
            case (kind_q)
              OP_FEED: begin
                digest_q <= mix_rsp_i.result;
                if (last_q) begin
                  mask_q <= mask_q | (64'd1 << bit_sel_q);
                  seen_q <= 1'b1;
                  cnt_q  <= '0;
                end else begin
                  cnt_q <= cnt_q + 64'd1;
                end
              end
              OP_WINDOW: begin
                digest_q <= mix_rsp_i.result;
                mask_q   <= mask_q | WINDOW_BIT;
                seen_q   <= 1'b1;
              end
              OP_FINISH: begin
                out_q       <= mix_rsp_i.result | 64'd1;
                out_valid_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        default: begin
          state_q <= BK_IDLE;
        end
      endcase
      // Writes must arrive only while the block is idle; the block does not enforce it.
      if (cfg_wr_i.valid) begin
        case (cfg_wr_i.index)
          REG_SEED:     digest_q   <= cfg_wr_i.data;
          REG_EXPECTED: expected_q <= cfg_wr_i.data;
          REG_REQUIRED: required_q <= cfg_wr_i.data;
          default: ;
        endcase
      end
    end
  end

endmodule
